// File: hdl/rar_pkg.sv
`timescale 1ns / 1ps

package rar_pkg;

  // Operation codes carried on the request channel
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Result field widths are fixed whatever the operand width
  localparam int RES_NUM_WIDTH = 33;
  localparam int RES_DEN_WIDTH = 32;

endpackage

// File: hdl/rar_in_if.sv
`timescale 1ns / 1ps

interface rar_in_if #(
  parameter int OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

// File: hdl/rar_out_if.sv
`timescale 1ns / 1ps

interface rar_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rar_pkg::RES_NUM_WIDTH-1:0] res_num;
  logic signed [rar_pkg::RES_DEN_WIDTH-1:0] res_den;
  logic                                     zero_den;

  modport source (output valid, res_num, res_den, zero_den, input ready);
  modport sink (input valid, res_num, res_den, zero_den, output ready);
endinterface

// File: hdl/rational_arith_reduce.sv
// Sequence: the multiply/setup states MUL0, MUL1, MUL2, SUM and CHECK, then TWOS strips common
//   factors of two, the binary GCD loop (one shift, swap or subtract a cycle), two bit-serial
//   divisions (numerator, then denominator) and FINISH to load; a zero n or d skips to FINISH.
// Throughput: one request at a time, since the GCD loop and both divisions share one subtractor;
//   a request is taken again from the cycle after the result loads (later while an old result waits).
// Reset: rst is synchronous, active high; it returns the sequencer to idle and empties the result.
`timescale 1ns / 1ps

module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  rar_in_if.sink    req_in,
  rar_out_if.source res_out
);
  import rar_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int NW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
  localparam int CW = $clog2(NW);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MUL0   = 11'b000_0000_0010,
    ST_MUL1   = 11'b000_0000_0100,
    ST_MUL2   = 11'b000_0000_1000,
    ST_SUM    = 11'b000_0001_0000,
    ST_CHECK  = 11'b000_0010_0000,
    ST_TWOS   = 11'b000_0100_0000,
    ST_GCD    = 11'b000_1000_0000,
    ST_DIVN   = 11'b001_0000_0000,
    ST_DIVD   = 11'b010_0000_0000,
    ST_FINISH = 11'b100_0000_0000
  } state_t;

  state_t state;

  cmd_t                            cmd_r;
  logic signed [OPERAND_WIDTH-1:0] an;
  logic signed [OPERAND_WIDTH-1:0] ad;
  logic signed [OPERAND_WIDTH-1:0] bn;
  logic signed [OPERAND_WIDTH-1:0] bd;
  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            p0;
  logic signed [NW-1:0]            n_r;
  logic signed [PW-1:0]            d_r;
  logic                            nneg;
  logic                            dneg;
  logic                            flag_r;
  logic [NW-1:0]                   u;
  logic [NW-1:0]                   v;
  logic [NW-1:0]                   dq;
  logic [NW-1:0]                   q;
  logic [NW-1:0]                   rem;
  logic [CW-1:0]                   cnt;

  logic signed [OPERAND_WIDTH-1:0] ma;
  logic signed [OPERAND_WIDTH-1:0] mb;
  logic signed [PW-1:0]            mul_p;
  logic signed [NW-1:0]            n_sum;
  logic [NW-1:0]                   n_mag;
  logic [PW-1:0]                   d_mag;
  logic                            in_div;
  logic [NW:0]                     alu_a;
  logic [NW:0]                     alu_diff;
  logic                            borrow;
  logic [NW-1:0]                   rem_next;
  logic [NW-1:0]                   q_next;
  logic [NW-1:0]                   q_sgn;

  assign req_in.ready = (state == ST_IDLE);

  // Select the operand pair for the shared multiplier
  always_comb begin
    if (state == ST_MUL0) begin
      ma = an;
      mb = (cmd_r == CMD_MUL) ? bn : bd;
    end else if (state == ST_MUL1) begin
      ma = bn;
      mb = ad;
    end else begin
      ma = ad;
      mb = (cmd_r == CMD_DIV) ? bn : bd;
    end
  end

  assign mul_p = ma * mb;

  // Form the raw numerator: cross-product sum (ADD) or difference (SUB), else p0 alone
  always_comb begin
    if (cmd_r == CMD_ADD) begin
      n_sum = NW'(p0) + NW'(prod);
    end else if (cmd_r == CMD_SUB) begin
      n_sum = NW'(p0) - NW'(prod);
    end else begin
      n_sum = NW'(p0);
    end
  end

  // Magnitudes of the raw result
  assign n_mag = n_r[NW-1] ? NW'(0) - $unsigned(n_r) : $unsigned(n_r);
  assign d_mag = d_r[PW-1] ? PW'(0) - $unsigned(d_r) : $unsigned(d_r);

  // Shared subtractor: GCD compare/subtract or one restoring division step
  assign in_div   = (state == ST_DIVN) || (state == ST_DIVD);
  assign alu_a    = in_div ? {rem, q[NW-1]} : {1'b0, u};
  assign alu_diff = alu_a - {1'b0, v};
  assign borrow   = alu_diff[NW];
  assign rem_next = borrow ? alu_a[NW-1:0] : alu_diff[NW-1:0];
  assign q_next   = {q[NW-2:0], ~borrow};
  assign q_sgn    = ((state == ST_DIVN) ? nneg : dneg) ? NW'(0) - q_next : q_next;

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      res_out.valid <= 1'b0;
    end else begin
      prod <= mul_p;
      // Drop a taken result unless the finishing step replaces it
      if (res_out.valid && res_out.ready && (state != ST_FINISH)) begin
        res_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_in.valid) begin
            cmd_r  <= cmd_t'(req_in.cmd);
            an     <= req_in.a_num;
            ad     <= req_in.a_den;
            bn     <= req_in.b_num;
            bd     <= req_in.b_den;
            flag_r <= 1'b0;
            state  <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          p0    <= prod;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          n_r   <= n_sum;
          state <= ST_SUM;
        end
        ST_SUM: begin
          d_r   <= prod;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (n_r == '0) begin
            d_r   <= PW'(1);
            state <= ST_FINISH;
          end else if (d_r == '0) begin
            flag_r <= 1'b1;
            state  <= ST_FINISH;
          end else begin
            nneg  <= n_r[NW-1];
            dneg  <= d_r[PW-1];
            u     <= n_mag;
            v     <= NW'(d_mag);
            state <= ST_TWOS;
          end
        end
        ST_TWOS: begin
          // Strip common factors of two; the shifted pair are the dividends
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
          end else begin
            q     <= u;
            dq    <= v;
            state <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (u == '0) begin
            rem   <= '0;
            cnt   <= CW'(NW - 1);
            state <= ST_DIVN;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (borrow) begin
            u <= v;
            v <= u;
          end else begin
            u <= alu_diff[NW-1:0];
          end
        end
        ST_DIVN: begin
          if (cnt == '0) begin
            n_r   <= q_sgn;
            q     <= dq;
            rem   <= '0;
            cnt   <= CW'(NW - 1);
            state <= ST_DIVD;
          end else begin
            rem <= rem_next;
            q   <= q_next;
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIVD: begin
          rem <= rem_next;
          q   <= q_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            d_r   <= q_sgn[PW-1:0];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the result register is free
          if (!res_out.valid || res_out.ready) begin
            res_out.valid    <= 1'b1;
            res_out.res_num  <= RES_NUM_WIDTH'(n_r);
            res_out.res_den  <= RES_DEN_WIDTH'(d_r);
            res_out.zero_den <= flag_r;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The GCD loop never runs with a zero divisor
  a_gcd_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_GCD |-> v != '0)
    else $error("GCD divisor reached zero");

  // Division by the GCD is always exact
  a_exact_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN || state == ST_DIVD) && cnt == '0 |-> rem_next == '0)
    else $error("division by GCD left a remainder");

  // A flagged result carries a zero denominator
  a_flag_den: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.zero_den |-> res_out.res_den == '0)
    else $error("zero_den set with nonzero denominator");

  // A new result appears only from the finishing step
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !$past(res_out.valid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside the finishing step");

endmodule
